@@ design/tlqe_pkg.sv @@
// tlqe_pkg: shared widths, constants, data types and helper functions
// for the thick line quad expander; no dependencies
package tlqe_pkg;

   localparam int COORD_W         = 24;
   localparam int THICK_W         = 8;
   localparam int MAG_W           = 24;
   localparam int SQ_W            = 2 * MAG_W;
   localparam int RAD_W           = 64;
   localparam int ROOT_W          = 32;
   localparam int LEN_EXT         = 7;
   localparam int COORD_FRAC_BITS = 8;
   localparam int DIR_FRAC_BITS   = 14;
   localparam int Q_W             = DIR_FRAC_BITS + 1;
   localparam int NUM_W           = 48;
   localparam int PROD_W          = Q_W + THICK_W;
   localparam int OFF_SHIFT       = DIR_FRAC_BITS - COORD_FRAC_BITS;
   localparam int OFF_W           = 16;
   localparam int SUM_W           = COORD_W + 2;

   localparam logic signed [SUM_W-1:0] CoordMax = SUM_W'(8388607);
   localparam logic signed [SUM_W-1:0] CoordMin = -SUM_W'(8388608);

   typedef struct packed {
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [COORD_W-1:0] x2;
      logic signed [COORD_W-1:0] y2;
      logic [THICK_W-1:0]        t1;
      logic [THICK_W-1:0]        t2;
      logic [MAG_W-1:0]          dxm;
      logic [MAG_W-1:0]          dym;
      logic                      px_neg;
      logic                      degen;
   } seg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] c0x;
      logic signed [COORD_W-1:0] c0y;
      logic signed [COORD_W-1:0] c1x;
      logic signed [COORD_W-1:0] c1y;
      logic signed [COORD_W-1:0] c2x;
      logic signed [COORD_W-1:0] c2y;
      logic signed [COORD_W-1:0] c3x;
      logic signed [COORD_W-1:0] c3y;
      logic                      degen;
   } res_type;

   // rounded offset in coordinate units from |comp| * pixels
   function automatic logic [OFF_W-1:0] round_off(logic [PROD_W-1:0] prod);
      logic [PROD_W:0] s;
      s = (PROD_W+1)'(prod) + (PROD_W+1)'(1 << (OFF_SHIFT - 1));
      return OFF_W'(s >> OFF_SHIFT);
   endfunction

   // move a coordinate by an offset and saturate
   function automatic logic signed [COORD_W-1:0] move_sat(logic signed [COORD_W-1:0] c,
                                                         logic [OFF_W-1:0] off,
                                                         logic sub);
      logic signed [SUM_W-1:0] o;
      logic signed [SUM_W-1:0] s;
      o = $signed(SUM_W'(off));
      s = sub ? SUM_W'(c) - o : SUM_W'(c) + o;
      if (s > CoordMax) begin
         s = CoordMax;
      end else if (s < CoordMin) begin
         s = CoordMin;
      end
      return s[COORD_W-1:0];
   endfunction

endpackage

@@ design/tlqe_prep.sv @@
// tlqe_prep: endpoint ordering, differences, squares and radicand
// depends on tlqe_pkg
module tlqe_prep (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic signed [tlqe_pkg::COORD_W-1:0] start_x,
   input  logic signed [tlqe_pkg::COORD_W-1:0] start_y,
   input  logic signed [tlqe_pkg::COORD_W-1:0] end_x,
   input  logic signed [tlqe_pkg::COORD_W-1:0] end_y,
   input  logic [tlqe_pkg::THICK_W-1:0]        start_thickness,
   input  logic [tlqe_pkg::THICK_W-1:0]        end_thickness,
   output logic                                 out_valid,
   output tlqe_pkg::seg_type                    out_seg,
   output logic [tlqe_pkg::RAD_W-1:0]           out_rad
);
   import tlqe_pkg::*;

   seg_type                  seg_in, seg_a_ff, seg_b_ff, seg_c_ff;
   logic [2:0]               valid_ff;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff;
   logic [RAD_W-1:0]         rad_ff;
   logic signed [COORD_W:0]  dx, dy;
   logic                     swap;
   logic [SQ_W:0]            sum;

   always_comb begin
      swap = (start_x > end_x) || ((start_x == end_x) && (start_y > end_y));
      seg_in.x1 = swap ? end_x : start_x;
      seg_in.y1 = swap ? end_y : start_y;
      seg_in.x2 = swap ? start_x : end_x;
      seg_in.y2 = swap ? start_y : end_y;
      seg_in.t1 = swap ? end_thickness : start_thickness;
      seg_in.t2 = swap ? start_thickness : end_thickness;
      dx = (COORD_W+1)'(seg_in.x2) - (COORD_W+1)'(seg_in.x1);
      dy = (COORD_W+1)'(seg_in.y2) - (COORD_W+1)'(seg_in.y1);
      seg_in.dxm = dx[MAG_W-1:0];
      seg_in.dym = dy[COORD_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
      seg_in.px_neg = !dy[COORD_W];
      seg_in.degen = (dx == '0) && (dy == '0);
      sum = (SQ_W+1)'(sqx_ff) + (SQ_W+1)'(sqy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         seg_a_ff <= seg_in;
         sqx_ff   <= seg_a_ff.dxm * seg_a_ff.dxm;
         sqy_ff   <= seg_a_ff.dym * seg_a_ff.dym;
         seg_b_ff <= seg_a_ff;
         rad_ff   <= RAD_W'(sum) << (2 * LEN_EXT);
         seg_c_ff <= seg_b_ff;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_seg   = seg_c_ff;
   assign out_rad   = rad_ff;

endmodule

@@ design/tlqe_sqrt.sv @@
// tlqe_sqrt: integer square root, one result bit per pipeline stage
// depends on tlqe_pkg
module tlqe_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  tlqe_pkg::seg_type          in_seg,
   input  logic [tlqe_pkg::RAD_W-1:0] in_rad,
   output logic                       out_valid,
   output tlqe_pkg::seg_type          out_seg,
   output logic [tlqe_pkg::ROOT_W-1:0] out_len
);
   import tlqe_pkg::*;

   logic [ROOT_W-1:0] valid_ff;
   logic [RAD_W-1:0]  v_ff [ROOT_W];
   logic [RAD_W-1:0]  r_ff [ROOT_W];
   seg_type           seg_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam logic [RAD_W-1:0] Bit = RAD_W'(1) << (RAD_W - 2 - 2 * k);
      logic [RAD_W-1:0] v_prev, r_prev, trial, v_in, r_in;
      logic             valid_prev;
      seg_type          seg_prev;

      if (k == 0) begin : g_first
         assign v_prev     = in_rad;
         assign r_prev     = '0;
         assign valid_prev = in_valid;
         assign seg_prev   = in_seg;
      end else begin : g_next
         assign v_prev     = v_ff[k-1];
         assign r_prev     = r_ff[k-1];
         assign valid_prev = valid_ff[k-1];
         assign seg_prev   = seg_ff[k-1];
      end

      always_comb begin
         trial = r_prev + Bit;
         if (v_prev >= trial) begin
            v_in = v_prev - trial;
            r_in = (r_prev >> 1) + Bit;
         end else begin
            v_in = v_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[k]   <= v_in;
            r_ff[k]   <= r_in;
            seg_ff[k] <= seg_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_seg   = seg_ff[ROOT_W-1];
   assign out_len   = r_ff[ROOT_W-1][ROOT_W-1:0];

endmodule

@@ design/tlqe_div.sv @@
// tlqe_div: rounded unit direction, restoring division one quotient bit a stage
// depends on tlqe_pkg
module tlqe_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  tlqe_pkg::seg_type           in_seg,
   input  logic [tlqe_pkg::ROOT_W-1:0] in_len,
   output logic                        out_valid,
   output tlqe_pkg::seg_type           out_seg,
   output logic [tlqe_pkg::Q_W-1:0]    out_qx,
   output logic [tlqe_pkg::Q_W-1:0]    out_qy
);
   import tlqe_pkg::*;

   localparam int NumShift = DIR_FRAC_BITS + LEN_EXT;

   logic              nvalid_ff;
   seg_type           nseg_ff;
   logic [NUM_W-1:0]  nx_ff, ny_ff;
   logic [ROOT_W-1:0] nlen_ff;

   logic [Q_W-1:0]    valid_ff;
   seg_type           seg_ff [Q_W];
   logic [NUM_W-1:0]  rx_ff [Q_W];
   logic [NUM_W-1:0]  ry_ff [Q_W];
   logic [Q_W-1:0]    qx_ff [Q_W];
   logic [Q_W-1:0]    qy_ff [Q_W];
   logic [ROOT_W-1:0] len_ff [Q_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         nvalid_ff <= 1'b0;
      end else if (en) begin
         nvalid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nseg_ff <= in_seg;
         nlen_ff <= in_len;
         nx_ff   <= (NUM_W'(in_seg.dxm) << NumShift) + NUM_W'(in_len >> 1);
         ny_ff   <= (NUM_W'(in_seg.dym) << NumShift) + NUM_W'(in_len >> 1);
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_stage
      logic [NUM_W-1:0]  rx_prev, ry_prev, dvs, rx_in, ry_in;
      logic [Q_W-1:0]    qx_prev, qy_prev;
      logic [ROOT_W-1:0] len_prev;
      logic              valid_prev, bx, by;
      seg_type           seg_prev;

      if (k == 0) begin : g_first
         assign rx_prev    = nx_ff;
         assign ry_prev    = ny_ff;
         assign qx_prev    = '0;
         assign qy_prev    = '0;
         assign len_prev   = nlen_ff;
         assign valid_prev = nvalid_ff;
         assign seg_prev   = nseg_ff;
      end else begin : g_next
         assign rx_prev    = rx_ff[k-1];
         assign ry_prev    = ry_ff[k-1];
         assign qx_prev    = qx_ff[k-1];
         assign qy_prev    = qy_ff[k-1];
         assign len_prev   = len_ff[k-1];
         assign valid_prev = valid_ff[k-1];
         assign seg_prev   = seg_ff[k-1];
      end

      always_comb begin
         dvs   = NUM_W'(len_prev) << (Q_W - 1 - k);
         bx    = rx_prev >= dvs;
         by    = ry_prev >= dvs;
         rx_in = bx ? rx_prev - dvs : rx_prev;
         ry_in = by ? ry_prev - dvs : ry_prev;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rx_ff[k]  <= rx_in;
            ry_ff[k]  <= ry_in;
            qx_ff[k]  <= {qx_prev[Q_W-2:0], bx};
            qy_ff[k]  <= {qy_prev[Q_W-2:0], by};
            len_ff[k] <= len_prev;
            seg_ff[k] <= seg_prev;
         end
      end
   end

   assign out_valid = valid_ff[Q_W-1];
   assign out_seg   = seg_ff[Q_W-1];
   assign out_qx    = seg_ff[Q_W-1].degen ? '0 : qx_ff[Q_W-1];
   assign out_qy    = seg_ff[Q_W-1].degen ? '0 : qy_ff[Q_W-1];

endmodule

@@ design/tlqe_corner.sv @@
// tlqe_corner: perpendicular offsets per endpoint and saturated quad corners
// depends on tlqe_pkg
module tlqe_corner (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  tlqe_pkg::seg_type        in_seg,
   input  logic [tlqe_pkg::Q_W-1:0] in_qx,
   input  logic [tlqe_pkg::Q_W-1:0] in_qy,
   output logic                     out_valid,
   output tlqe_pkg::res_type        out_res
);
   import tlqe_pkg::*;

   logic [1:0]         valid_ff;
   seg_type            seg_ff;
   logic [PROD_W-1:0]  px_h1_ff, px_r1_ff, px_h2_ff, px_r2_ff;
   logic [PROD_W-1:0]  py_h1_ff, py_r1_ff, py_h2_ff, py_r2_ff;
   logic [THICK_W-1:0] h1, r1, h2, r2;
   res_type            res_in, res_ff;

   always_comb begin
      h1 = in_seg.t1 >> 1;
      r1 = in_seg.t1 - h1;
      h2 = in_seg.t2 >> 1;
      r2 = in_seg.t2 - h2;
      res_in.c0x   = move_sat(seg_ff.x1, round_off(px_h1_ff), !seg_ff.px_neg);
      res_in.c0y   = move_sat(seg_ff.y1, round_off(py_h1_ff), 1'b1);
      res_in.c1x   = move_sat(seg_ff.x2, round_off(px_h2_ff), !seg_ff.px_neg);
      res_in.c1y   = move_sat(seg_ff.y2, round_off(py_h2_ff), 1'b1);
      res_in.c2x   = move_sat(seg_ff.x2, round_off(px_r2_ff), seg_ff.px_neg);
      res_in.c2y   = move_sat(seg_ff.y2, round_off(py_r2_ff), 1'b0);
      res_in.c3x   = move_sat(seg_ff.x1, round_off(px_r1_ff), seg_ff.px_neg);
      res_in.c3y   = move_sat(seg_ff.y1, round_off(py_r1_ff), 1'b0);
      res_in.degen = seg_ff.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         seg_ff   <= in_seg;
         px_h1_ff <= in_qy * h1;
         px_r1_ff <= in_qy * r1;
         px_h2_ff <= in_qy * h2;
         px_r2_ff <= in_qy * r2;
         py_h1_ff <= in_qx * h1;
         py_r1_ff <= in_qx * r1;
         py_h2_ff <= in_qx * h2;
         py_r2_ff <= in_qx * r2;
         res_ff   <= res_in;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_res   = res_ff;

endmodule

@@ design/thick_line_quad_expand.sv @@
// thick_line_quad_expand: top level of the thick line to quad expander
// depends on tlqe_pkg, tlqe_prep, tlqe_sqrt, tlqe_div, tlqe_corner
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  two endpoints, two thicknesses
//   rsp_      out         rsp_valid/rsp_stall  four corners, degenerate flag
//
// one transfer per cycle while the output is not stalled; stages: 3 prep, 32 square root bit
// stages, 16 division, 2 corner stages
// synchronous reset clears the valid bits of every stage
// the whole pipeline holds while a result waits stalled at the output
// register; bubbles move on otherwise
module thick_line_quad_expand (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_start_x,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_start_y,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_end_x,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_end_y,
   input  logic [tlqe_pkg::THICK_W-1:0]        req_start_thickness,
   input  logic [tlqe_pkg::THICK_W-1:0]        req_end_thickness,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner0_x,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner0_y,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner1_x,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner1_y,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner2_x,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner2_y,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner3_x,
   output logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner3_y,
   output logic                                 rsp_degenerate
);
   import tlqe_pkg::*;

   logic              en;
   logic              prep_valid, sqrt_valid, div_valid;
   seg_type           prep_seg, sqrt_seg, div_seg;
   logic [RAD_W-1:0]  prep_rad;
   logic [ROOT_W-1:0] sqrt_len;
   logic [Q_W-1:0]    div_qx, div_qy;
   res_type           res;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   tlqe_prep u_prep (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (req_valid),
      .start_x         (req_start_x),
      .start_y         (req_start_y),
      .end_x           (req_end_x),
      .end_y           (req_end_y),
      .start_thickness (req_start_thickness),
      .end_thickness   (req_end_thickness),
      .out_valid       (prep_valid),
      .out_seg         (prep_seg),
      .out_rad         (prep_rad)
   );

   tlqe_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (prep_valid),
      .in_seg    (prep_seg),
      .in_rad    (prep_rad),
      .out_valid (sqrt_valid),
      .out_seg   (sqrt_seg),
      .out_len   (sqrt_len)
   );

   tlqe_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sqrt_valid),
      .in_seg    (sqrt_seg),
      .in_len    (sqrt_len),
      .out_valid (div_valid),
      .out_seg   (div_seg),
      .out_qx    (div_qx),
      .out_qy    (div_qy)
   );

   tlqe_corner u_corner (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_valid),
      .in_seg    (div_seg),
      .in_qx     (div_qx),
      .in_qy     (div_qy),
      .out_valid (rsp_valid),
      .out_res   (res)
   );

   assign rsp_corner0_x  = res.c0x;
   assign rsp_corner0_y  = res.c0y;
   assign rsp_corner1_x  = res.c1x;
   assign rsp_corner1_y  = res.c1y;
   assign rsp_corner2_x  = res.c2x;
   assign rsp_corner2_y  = res.c2y;
   assign rsp_corner3_x  = res.c3x;
   assign rsp_corner3_y  = res.c3y;
   assign rsp_degenerate = res.degen;

endmodule

@@ dv/thick_line_quad_expand_checker.sv @@
// thick_line_quad_expand_checker: watches both channels of the quad expander,
// predicts each quad from the accepted segment and compares field by field
// depends on tlqe_pkg for the coordinate and thickness widths and the fraction bits
module thick_line_quad_expand_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_start_x,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_start_y,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_end_x,
   input  logic signed [tlqe_pkg::COORD_W-1:0] req_end_y,
   input  logic [tlqe_pkg::THICK_W-1:0]        req_start_thickness,
   input  logic [tlqe_pkg::THICK_W-1:0]        req_end_thickness,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner0_x,
   input  logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner0_y,
   input  logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner1_x,
   input  logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner1_y,
   input  logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner2_x,
   input  logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner2_y,
   input  logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner3_x,
   input  logic signed [tlqe_pkg::COORD_W-1:0] rsp_corner3_y,
   input  logic                                 rsp_degenerate,
   output int                                   fail_count,
   output int                                   pending_quads,
   output int                                   quad_count,
   output int                                   degen_count,
   output int                                   sat_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import tlqe_pkg::*;

   localparam int LenExt = 7;
   localparam longint CoordLo = -8388608;
   localparam longint CoordHi = 8388607;

   typedef struct packed {
      logic [COORD_W*8-1:0] corners;
      logic                 degen;
   } quad_type;

   quad_type quad_queue[$];

   function automatic longint isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint dir_comp(longint d, longint unsigned len);
      longint unsigned m, q;
      m = d < 0 ? -d : d;
      q = ((m << (DIR_FRAC_BITS + LenExt)) + len / 2) / len;
      return d < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint shift_of(longint comp, longint unsigned n);
      longint unsigned m, q;
      m = comp < 0 ? -comp : comp;
      q = (((m * n) << COORD_FRAC_BITS) + (64'd1 << (DIR_FRAC_BITS - 1))) >> DIR_FRAC_BITS;
      return comp < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [COORD_W-1:0] clamp(longint v, ref bit hit);
      if (v < CoordLo) begin
         hit = 1;
         v = CoordLo;
      end else if (v > CoordHi) begin
         hit = 1;
         v = CoordHi;
      end
      return v[COORD_W-1:0];
   endfunction

   function automatic quad_type expand_segment(longint x1, longint y1, longint x2, longint y2,
                                              longint unsigned t1, longint unsigned t2,
                                              ref bit hit);
      quad_type q;
      longint tx, ty, dx, dy, px, py;
      longint unsigned tt, len, h1, h2, r1, r2;
      px = 0;
      py = 0;
      if (x1 > x2 || (x1 == x2 && y1 > y2)) begin
         tx = x1; ty = y1; tt = t1;
         x1 = x2; y1 = y2; t1 = t2;
         x2 = tx; y2 = ty; t2 = tt;
      end
      dx = x2 - x1;
      dy = y2 - y1;
      q.degen = (dx == 0 && dy == 0);
      if (!q.degen) begin
         len = isqrt((dx * dx + dy * dy) << (2 * LenExt));
         px = -dir_comp(dy, len);
         py = dir_comp(dx, len);
      end
      h1 = t1 / 2; r1 = t1 - h1;
      h2 = t2 / 2; r2 = t2 - h2;
      q.corners = {clamp(x1 - shift_of(px, h1), hit), clamp(y1 - shift_of(py, h1), hit),
                   clamp(x2 - shift_of(px, h2), hit), clamp(y2 - shift_of(py, h2), hit),
                   clamp(x2 + shift_of(px, r2), hit), clamp(y2 + shift_of(py, r2), hit),
                   clamp(x1 + shift_of(px, r1), hit), clamp(y1 + shift_of(py, r1), hit)};
      return q;
   endfunction

   always @(posedge clock) begin
      quad_type want, got;
      bit hit;
      if (reset) begin
         quad_queue.delete();
         fail_count <= 0;
         pending_quads <= 0;
         quad_count <= 0;
         degen_count <= 0;
         sat_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            hit = 0;
            want = expand_segment(req_start_x, req_start_y, req_end_x, req_end_y,
                                  req_start_thickness, req_end_thickness, hit);
            quad_queue.push_back(want);
            if (want.degen) degen_count <= degen_count + 1;
            if (hit) sat_count <= sat_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            got.corners = {rsp_corner0_x, rsp_corner0_y, rsp_corner1_x, rsp_corner1_y,
                           rsp_corner2_x, rsp_corner2_y, rsp_corner3_x, rsp_corner3_y};
            got.degen = rsp_degenerate;
            quad_count <= quad_count + 1;
            if (quad_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected quad %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = quad_queue.pop_front();
               if (got != want) begin
                  if (fail_count < 10) begin
                     $display("quad %0d mismatch", quad_count);
                     for (int i = 7; i >= 0; i--)
                        $display("  coord %0d: expected %0d actual %0d", 7 - i,
                                 $signed(want.corners[i*COORD_W +: COORD_W]),
                                 $signed(got.corners[i*COORD_W +: COORD_W]));
                     $display("  degenerate: expected %0b actual %0b", want.degen, got.degen);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_quads <= quad_queue.size();
      end
   end

endmodule

@@ dv/thick_line_quad_expand_test.sv @@
// thick_line_quad_expand_test: drives line segments into the quad expander
// and gives the verdict; depends on tlqe_pkg, the block and the checker
module thick_line_quad_expand_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tlqe_pkg::*;

   localparam int Latency = 53;
   localparam int RandomSegments = 650;
   localparam longint CycleLimit = 200000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [COORD_W-1:0] req_start_x = 0, req_start_y = 0, req_end_x = 0, req_end_y = 0;
   logic [THICK_W-1:0] req_start_thickness = 0, req_end_thickness = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [COORD_W-1:0] rsp_corner0_x, rsp_corner0_y, rsp_corner1_x, rsp_corner1_y;
   logic signed [COORD_W-1:0] rsp_corner2_x, rsp_corner2_y, rsp_corner3_x, rsp_corner3_y;
   logic rsp_degenerate;
   int fail_count, pending_quads, quad_count, degen_count, sat_count;
   longint cycle_count = 0;
   int sent = 0;
   bit calm = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   thick_line_quad_expand uut (.*);
   thick_line_quad_expand_checker checker_inst (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** thick_line_quad_expand: FAILED **");
         $finish;
      end
   end

   // receiver back-pressure in bursts
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 9);
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
            rsp_stall <= 0;
         end
         @(negedge clock);
      end
   end

   task automatic send(input logic [COORD_W-1:0] sx, sy, ex, ey,
                       input logic [THICK_W-1:0] st, et);
      int n;
      if (!calm && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 9);
         req_valid <= 0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1;
      req_start_x <= sx; req_start_y <= sy; req_end_x <= ex; req_end_y <= ey;
      req_start_thickness <= st; req_end_thickness <= et;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic [COORD_W-1:0] rand_coord(int mode);
      case (mode)
         0: return COORD_W'($urandom);
         1: return COORD_W'($urandom_range(0, 4095) - 2048);
         2: return $urandom_range(0, 1) ? COORD_W'(24'h7fffff - $urandom_range(0, 255))
                                       : COORD_W'(24'h800000 + $urandom_range(0, 255));
         default: return COORD_W'($urandom_range(0, 65535) - 32768);
      endcase
   endfunction

   initial begin
      logic [COORD_W-1:0] ax, ay;
      int m;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // extremes, orderings, coincident points and saturation
      send(0, 0, 0, 0, 0, 0);
      send(24'h100, 24'h100, 24'h100, 24'h100, 255, 255);
      send(0, 0, 24'h1000, 0, 1, 2);
      send(24'h1000, 0, 0, 0, 2, 1);
      send(0, 24'h1000, 0, 0, 3, 200);
      send(0, 0, 0, 24'h1000, 255, 0);
      send(0, 0, 24'h1, 24'h1, 10, 11);
      send(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 255, 255);
      send(24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000, 255, 254);
      send(24'h7fffff, 0, 24'h7ffff0, 24'h7fffff, 255, 255);
      send(24'h800000, 24'h800000, 24'h800000, 24'h800001, 128, 127);
      send(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 1, 0);
      send(24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555, 8'h55, 8'haa);
      send(24'h123456, 24'h0, 24'h123457, 24'h7, 17, 64);
      req_valid <= 0;
      // let the pipeline drain completely before the random part
      while (pending_quads != 0 || sent != quad_count) @(negedge clock);
      for (int i = 0; i < RandomSegments; i++) begin
         if (i == RandomSegments - 80) calm = 1;
         m = $urandom_range(0, 3);
         ax = rand_coord(m);
         ay = rand_coord(m);
         if ($urandom_range(0, 19) == 0)
            send(ax, ay, ax, ay, THICK_W'($urandom), THICK_W'($urandom));
         else if ($urandom_range(0, 9) == 0)
            send(ax, ay, $urandom_range(0, 1) ? ax : rand_coord(m),
                 $urandom_range(0, 1) ? ay : rand_coord(m),
                 THICK_W'($urandom), THICK_W'($urandom));
         else
            send(ax, ay, rand_coord(m), rand_coord(m), THICK_W'($urandom), THICK_W'($urandom));
      end
      req_valid <= 0;
      while (pending_quads != 0 || sent != quad_count) @(negedge clock);
      repeat (Latency + 10) @(negedge clock);
      $display("%0d segments sent, %0d quads checked", sent, quad_count);
      $display("%0d coincident endpoint cases, %0d with clamped corners",
               degen_count, sat_count);
      if (fail_count == 0 && pending_quads == 0)
         $display("** thick_line_quad_expand: PASSED **");
      else
         $display("** thick_line_quad_expand: FAILED **");
      $finish;
   end

endmodule
